FILE: hdl/rsi_pkg.sv
package rsi_pkg;

  // Configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_TRANSPARENT = 3'd4
  } cfg_reg_t;

  // Handshake opcodes
  localparam logic OP_OUTER = 1'b0;
  localparam logic OP_EXIT  = 1'b1;

endpackage

FILE: hdl/rsi_isqrt.sv
module rsi_isqrt #(
  parameter int RAD_W = 72,
  parameter int SB_W  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     rad,
  input  logic [SB_W-1:0]      sb_in,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   root,
  output logic [SB_W-1:0]      sb_out
);

  // One root bit per stage, floored integer square root
  localparam int N     = RAD_W / 2;
  localparam int REM_W = N + 2;

  logic             vld_q  [N];
  logic [REM_W-1:0] rem_q  [N];
  logic [N-1:0]     root_q [N];
  logic [RAD_W-1:0] rad_q  [N];
  logic [SB_W-1:0]  sb_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             vld_i;
    logic [REM_W-1:0] rem_i;
    logic [N-1:0]     root_i;
    logic [RAD_W-1:0] rad_i;
    logic [SB_W-1:0]  sb_i;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
      assign sb_i   = sb_in;
    end else begin : g_next
      assign vld_i  = vld_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
      assign sb_i   = sb_q[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_q[k] <= {root_i[N-2:0], ge};
        rad_q[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        sb_q[k]   <= sb_i;
      end
    end
  end

  assign out_vld = vld_q[N-1];
  assign root    = root_q[N-1];
  assign sb_out  = sb_q[N-1];

endmodule

FILE: hdl/rsi_ndiv.sv
module rsi_ndiv #(
  parameter int NUM_W = 33,
  parameter int Q_W   = 17,
  parameter int SB_W  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [2:0][NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]       den,
  input  logic [SB_W-1:0]        sb_in,
  output logic                   out_vld,
  output logic [2:0][Q_W-1:0]    quo,
  output logic [SB_W-1:0]        sb_out
);

  // Three lanes share one divisor; numerator never exceeds divisor,
  // quotient is (num << (Q_W-1)) / den, one bit per stage
  logic                  vld_q [Q_W];
  logic [2:0][NUM_W-1:0] rem_q [Q_W];
  logic [2:0][Q_W-1:0]   quo_q [Q_W];
  logic [NUM_W-1:0]      den_q [Q_W];
  logic [SB_W-1:0]       sb_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic                  vld_i;
    logic [2:0][NUM_W-1:0] rem_i;
    logic [2:0][Q_W-1:0]   quo_i;
    logic [NUM_W-1:0]      den_i;
    logic [SB_W-1:0]       sb_i;
    logic [2:0][NUM_W-1:0] rem_n;
    logic [2:0][Q_W-1:0]   quo_n;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = num;
      assign quo_i = '0;
      assign den_i = den;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign vld_i = vld_q[k-1];
      assign rem_i = rem_q[k-1];
      assign quo_i = quo_q[k-1];
      assign den_i = den_q[k-1];
      assign sb_i  = sb_q[k-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [NUM_W:0] cur;
      logic [NUM_W:0] diff;
      logic           ge;

      // first stage takes the numerator as is, later ones shift in a zero
      assign cur  = (k == 0) ? {1'b0, rem_i[j]} : {rem_i[j], 1'b0};
      assign diff = cur - {1'b0, den_i};
      assign ge   = (cur >= {1'b0, den_i});
      assign rem_n[j] = ge ? diff[NUM_W-1:0] : cur[NUM_W-1:0];
      assign quo_n[j] = {quo_i[j][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_n;
        quo_q[k] <= quo_n;
        den_q[k] <= den_i;
        sb_q[k]  <= sb_i;
      end
    end
  end

  assign out_vld = vld_q[Q_W-1];
  assign quo     = quo_q[Q_W-1];
  assign sb_out  = sb_q[Q_W-1];

endmodule

FILE: hdl/ray_sphere_intersect.sv
// Ray / sphere intersection, fully pipelined, one ray per clock.
// Config port: write cfg_data to register cfg_index when cfg_we is high
// (center x/y/z, radius, transparent flag). Write only while the pipe is empty.
// Ray channel: a word (opcode, start, dir) is taken when ray_valid is high
// and ray_stall is low. Result channel: one word per ray (hit, distance,
// point, normal, transparent_hit), taken when res_valid is high and
// res_stall is low. A miss returns hit=0 with every other field zero.
// Throughput: one ray per cycle while res_stall does not hold a result. Most
// of the pipeline's stages lie in the two square-root pipelines (one root
// bit per stage) and the normalizing divider (one quotient bit per stage).
// Stall: when a result is held on res_stall the whole pipeline freezes and
// ray_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset: rst is synchronous; it empties the pipeline and sets the sphere
// to center 0, radius 1.0, opaque.
module ray_sphere_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  input  logic                              ray_valid,
  output logic                              ray_stall,
  input  logic                              opcode,
  input  logic signed [COORD_WIDTH-1:0]     start_x,
  input  logic signed [COORD_WIDTH-1:0]     start_y,
  input  logic signed [COORD_WIDTH-1:0]     start_z,
  input  logic signed [FRAC_BITS+1:0]       dir_x,
  input  logic signed [FRAC_BITS+1:0]       dir_y,
  input  logic signed [FRAC_BITS+1:0]       dir_z,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              hit,
  output logic [COORD_WIDTH-2:0]            distance,
  output logic signed [COORD_WIDTH-1:0]     point_x,
  output logic signed [COORD_WIDTH-1:0]     point_y,
  output logic signed [COORD_WIDTH-1:0]     point_z,
  output logic signed [FRAC_BITS+1:0]       normal_x,
  output logic signed [FRAC_BITS+1:0]       normal_y,
  output logic signed [FRAC_BITS+1:0]       normal_z,
  output logic                              transparent_hit
);
  import rsi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = FB + 2;          // direction / normal
  localparam int DTW  = CW - 1;          // radius / distance
  localparam int LW   = CW + 1;          // center - origin
  localparam int PW   = LW + DW;         // L*dir product
  localparam int TCW  = PW + 2;          // dot product sum
  localparam int TQW  = TCW - FB - 1;    // floored projection, non-negative
  localparam int TQK  = TQW / 2;
  localparam int TQH  = TQW - TQK;
  localparam int RADW = 2 * TQW + 2;     // thc radicand
  localparam int RTW  = RADW / 2;
  localparam int TW   = TQW + 2;
  localparam int TDW  = DTW + 1 + DW;    // t*dir
  localparam int PSW  = CW + 3;
  localparam int VW   = CW + 1;
  localparam int VSW  = 2 * CW + 2;
  localparam int NRW  = VSW / 2;
  localparam int QW   = FB + 1;
  localparam logic [DTW-1:0] DMAX = '1;

  typedef struct packed {
    logic                 op;
    logic                 miss;
    logic [TQW-1:0]       tq;
    logic [2:0][CW-1:0]   s;
    logic [2:0][DW-1:0]   d;
  } sb1_t;

  typedef struct packed {
    logic                 op;
    logic                 miss;
    logic [DTW-1:0]       t;
    logic [2:0][CW-1:0]   p;
    logic [2:0]           vneg;
    logic [2:0][CW-1:0]   vm;
  } sb2_t;

  typedef struct packed {
    logic                 op;
    logic                 miss;
    logic                 nz;
    logic [DTW-1:0]       t;
    logic [2:0][CW-1:0]   p;
    logic [2:0]           vneg;
  } sb3_t;

  // Configuration registers
  logic [2:0][CW-1:0] ctr;
  logic [DTW-1:0]     radius;
  logic               transp;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr    <= '0;
      radius <= DTW'(1) << FB;
      transp <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    ctr[0] <= cfg_data;
        REG_CENTER_Y:    ctr[1] <= cfg_data;
        REG_CENTER_Z:    ctr[2] <= cfg_data;
        REG_RADIUS:      radius <= cfg_data[DTW-1:0];
        REG_TRANSPARENT: transp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipe moves unless the output word is held
  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign ray_stall = !adv;

  logic [2:0][CW-1:0] s_in;
  logic [2:0][DW-1:0] d_in;
  assign s_in = {start_z, start_y, start_x};
  assign d_in = {dir_z, dir_y, dir_x};

  // Stage a: L = center - origin
  logic               a_vld, a_op;
  logic [2:0][CW-1:0] a_s;
  logic [2:0][DW-1:0] a_d;
  logic signed [LW-1:0] a_l [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op <= opcode;
      a_s  <= s_in;
      a_d  <= d_in;
      for (int i = 0; i < 3; i++) begin
        a_l[i] <= LW'($signed(ctr[i])) - LW'($signed(s_in[i]));
      end
    end
  end

  // Stage b: L*dir and L*L products
  logic [CW-1:0] a_lm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_lm[i] = a_l[i][LW-1] ? CW'(-a_l[i]) : CW'(a_l[i]);
    end
  end

  logic               b_vld, b_op;
  logic [2:0][CW-1:0] b_s;
  logic [2:0][DW-1:0] b_d;
  logic signed [PW-1:0] b_prod [3];
  logic [2*CW-1:0]      b_lsq  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op <= a_op;
      b_s  <= a_s;
      b_d  <= a_d;
      for (int i = 0; i < 3; i++) begin
        b_prod[i] <= a_l[i] * $signed(a_d[i]);
        b_lsq[i]  <= a_lm[i] * a_lm[i];
      end
    end
  end

  // Stage c: tca and |L|^2 sums
  logic signed [TCW-1:0] b_tca;
  logic [2*CW+1:0]       b_ll;
  assign b_tca = TCW'(b_prod[0]) + TCW'(b_prod[1]) + TCW'(b_prod[2]);
  assign b_ll  = (2*CW+2)'(b_lsq[0]) + (2*CW+2)'(b_lsq[1]) + (2*CW+2)'(b_lsq[2]);

  logic               c_vld, c_op, c_neg;
  logic [TQW-1:0]     c_tq;
  logic [2*CW+1:0]    c_ll;
  logic [2:0][CW-1:0] c_s;
  logic [2:0][DW-1:0] c_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op  <= b_op;
      c_neg <= b_tca[TCW-1];
      c_tq  <= b_tca[FB +: TQW];
      c_ll  <= b_ll;
      c_s   <= b_s;
      c_d   <= b_d;
    end
  end

  // Stage e: tq^2 as split partial products, radius^2
  logic [TQH-1:0]     c_hi;
  logic [TQK-1:0]     c_lo;
  assign c_hi = c_tq[TQW-1:TQK];
  assign c_lo = c_tq[TQK-1:0];

  logic               e_vld, e_op, e_neg;
  logic [2*TQH-1:0]   e_hh;
  logic [TQH+TQK-1:0] e_hl;
  logic [2*TQK-1:0]   e_lo;
  logic [2*DTW-1:0]   e_r2;
  logic [TQW-1:0]     e_tq;
  logic [2*CW+1:0]    e_ll;
  logic [2:0][CW-1:0] e_s;
  logic [2:0][DW-1:0] e_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_hh  <= c_hi * c_hi;
      e_hl  <= c_hi * c_lo;
      e_lo  <= c_lo * c_lo;
      e_r2  <= radius * radius;
      e_op  <= c_op;
      e_neg <= c_neg;
      e_tq  <= c_tq;
      e_ll  <= c_ll;
      e_s   <= c_s;
      e_d   <= c_d;
    end
  end

  // Stage f: rhs = r^2 + tq^2
  logic               f_vld, f_op, f_neg;
  logic [RADW-1:0]    f_rhs;
  logic [TQW-1:0]     f_tq;
  logic [2*CW+1:0]    f_ll;
  logic [2:0][CW-1:0] f_s;
  logic [2:0][DW-1:0] f_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rhs <= RADW'(e_r2) + (RADW'(e_hh) << (2*TQK)) + (RADW'(e_hl) << (TQK+1))
             + RADW'(e_lo);
      f_op  <= e_op;
      f_neg <= e_neg;
      f_tq  <= e_tq;
      f_ll  <= e_ll;
      f_s   <= e_s;
      f_d   <= e_d;
    end
  end

  // Stage g: miss decision and thc radicand
  logic               g_vld, g_op, g_miss;
  logic [RADW-1:0]    g_rad;
  logic [TQW-1:0]     g_tq;
  logic [2:0][CW-1:0] g_s;
  logic [2:0][DW-1:0] g_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_miss <= f_neg || ((f_op == OP_OUTER) && (f_rhs < RADW'(f_ll)));
      g_rad  <= f_rhs - RADW'(f_ll);
      g_op   <= f_op;
      g_tq   <= f_tq;
      g_s    <= f_s;
      g_d    <= f_d;
    end
  end

  // thc = sqrt(r^2 - |L|^2 + tq^2)
  sb1_t g_sb, q1_sb;
  logic q1_vld;
  logic [RTW-1:0] q1_root;

  always_comb begin
    g_sb.op   = g_op;
    g_sb.miss = g_miss;
    g_sb.tq   = g_tq;
    g_sb.s    = g_s;
    g_sb.d    = g_d;
  end

  rsi_isqrt #(
    .RAD_W (RADW),
    .SB_W  ($bits(sb1_t))
  ) u_sqrt_thc (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (g_vld),
    .rad     (g_rad),
    .sb_in   (g_sb),
    .out_vld (q1_vld),
    .root    (q1_root),
    .sb_out  (q1_sb)
  );

  // Stage h: pick root, saturate distance
  logic signed [TW:0] h_near;
  logic [TW-1:0]      h_far;
  logic [TW-1:0]      h_traw;
  assign h_near = $signed({2'b00, q1_sb.tq}) - $signed({1'b0, q1_root});
  assign h_far  = TW'(q1_sb.tq) + TW'(q1_root);

  always_comb begin
    if (q1_sb.op == OP_EXIT) begin
      h_traw = TW'({q1_sb.tq, 1'b0});
    end else if (h_near < 0) begin
      h_traw = h_far;
    end else begin
      h_traw = h_near[TW-1:0];
    end
  end

  logic               h_vld, h_op, h_miss;
  logic [DTW-1:0]     h_t;
  logic [2:0][CW-1:0] h_s;
  logic [2:0][DW-1:0] h_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_t    <= (h_traw > TW'(DMAX)) ? DMAX : h_traw[DTW-1:0];
      h_op   <= q1_sb.op;
      h_miss <= q1_sb.miss;
      h_s    <= q1_sb.s;
      h_d    <= q1_sb.d;
    end
  end

  // Stage i: t*dir
  logic               i_vld, i_op, i_miss;
  logic [DTW-1:0]     i_t;
  logic [2:0][CW-1:0] i_s;
  logic signed [TDW-1:0] i_td [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (adv) begin
      i_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        i_td[i] <= $signed({1'b0, h_t}) * $signed(h_d[i]);
      end
      i_t    <= h_t;
      i_op   <= h_op;
      i_miss <= h_miss;
      i_s    <= h_s;
    end
  end

  // Stage j: hit point with saturation
  logic signed [TDW-1:0] i_sh  [3];
  logic signed [PSW-1:0] i_sum [3];
  logic [CW-1:0]         i_pc  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      i_sh[i]  = i_td[i] >>> FB;
      i_sum[i] = PSW'($signed(i_s[i])) + PSW'(i_sh[i]);
      if ((i_sum[i][PSW-1:CW-1] == '0) || (i_sum[i][PSW-1:CW-1] == '1)) begin
        i_pc[i] = i_sum[i][CW-1:0];
      end else if (i_sum[i][PSW-1]) begin
        i_pc[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        i_pc[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  logic               j_vld, j_op, j_miss;
  logic [DTW-1:0]     j_t;
  logic [2:0][CW-1:0] j_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (adv) begin
      j_vld <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        j_p[i] <= i_pc[i];
      end
      j_t    <= i_t;
      j_op   <= i_op;
      j_miss <= i_miss;
    end
  end

  // Stage k: V = point - center, sign and magnitude
  logic signed [VW-1:0] j_v [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      j_v[i] = VW'($signed(j_p[i])) - VW'($signed(ctr[i]));
    end
  end

  logic               k_vld, k_op, k_miss;
  logic [DTW-1:0]     k_t;
  logic [2:0][CW-1:0] k_p;
  logic [2:0]         k_vneg;
  logic [2:0][CW-1:0] k_vm;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (adv) begin
      k_vld <= j_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        k_vneg[i] <= j_v[i][VW-1];
        k_vm[i]   <= j_v[i][VW-1] ? CW'(-j_v[i]) : CW'(j_v[i]);
      end
      k_p    <= j_p;
      k_t    <= j_t;
      k_op   <= j_op;
      k_miss <= j_miss;
    end
  end

  // Stage m: V component squares
  logic               m_vld, m_op, m_miss;
  logic [DTW-1:0]     m_t;
  logic [2:0][CW-1:0] m_p;
  logic [2:0]         m_vneg;
  logic [2:0][CW-1:0] m_vm;
  logic [2*CW-1:0]    m_vsq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_vsq[i] <= k_vm[i] * k_vm[i];
      end
      m_p    <= k_p;
      m_t    <= k_t;
      m_op   <= k_op;
      m_miss <= k_miss;
      m_vneg <= k_vneg;
      m_vm   <= k_vm;
    end
  end

  // Stage n: |V|^2
  logic            n_vld;
  logic [VSW-1:0]  n_vss;
  sb2_t            n_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_vss     <= VSW'(m_vsq[0]) + VSW'(m_vsq[1]) + VSW'(m_vsq[2]);
      n_sb.op   <= m_op;
      n_sb.miss <= m_miss;
      n_sb.t    <= m_t;
      n_sb.p    <= m_p;
      n_sb.vneg <= m_vneg;
      n_sb.vm   <= m_vm;
    end
  end

  // Normal length
  logic           q2_vld;
  logic [NRW-1:0] q2_root;
  sb2_t           q2_sb;

  rsi_isqrt #(
    .RAD_W (VSW),
    .SB_W  ($bits(sb2_t))
  ) u_sqrt_len (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (n_vld),
    .rad     (n_vss),
    .sb_in   (n_sb),
    .out_vld (q2_vld),
    .root    (q2_root),
    .sb_out  (q2_sb)
  );

  // Normalize: (|V| << FB) / |V|len for each component
  logic [2:0][NRW-1:0] dv_num;
  sb3_t                dv_sb_in, dv_sb;
  logic                dv_vld;
  logic [2:0][QW-1:0]  dv_quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[i] = NRW'(q2_sb.vm[i]);
    end
    dv_sb_in.op   = q2_sb.op;
    dv_sb_in.miss = q2_sb.miss;
    dv_sb_in.nz   = (q2_root != '0);
    dv_sb_in.t    = q2_sb.t;
    dv_sb_in.p    = q2_sb.p;
    dv_sb_in.vneg = q2_sb.vneg;
  end

  rsi_ndiv #(
    .NUM_W (NRW),
    .Q_W   (QW),
    .SB_W  ($bits(sb3_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (q2_vld),
    .num     (dv_num),
    .den     (q2_root),
    .sb_in   (dv_sb_in),
    .out_vld (dv_vld),
    .quo     (dv_quo),
    .sb_out  (dv_sb)
  );

  // Output register
  logic signed [DW-1:0] nrm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_sb.nz || dv_sb.miss) begin
        nrm[i] = '0;
      end else if (dv_sb.vneg[i]) begin
        nrm[i] = -$signed(DW'(dv_quo[i]));
      end else begin
        nrm[i] = $signed(DW'(dv_quo[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit             <= !dv_sb.miss;
      distance        <= dv_sb.miss ? '0 : dv_sb.t;
      point_x         <= dv_sb.miss ? '0 : dv_sb.p[0];
      point_y         <= dv_sb.miss ? '0 : dv_sb.p[1];
      point_z         <= dv_sb.miss ? '0 : dv_sb.p[2];
      normal_x        <= nrm[0];
      normal_y        <= nrm[1];
      normal_z        <= nrm[2];
      transparent_hit <= !dv_sb.miss && (dv_sb.op == OP_OUTER) && transp;
    end
  end

  // Checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !hit) |-> (distance == '0 && point_x == '0 && normal_x == '0
                             && !transparent_hit))
    else $error("miss word carries nonzero fields");

  a_transp_hit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && transparent_hit) |-> hit)
    else $error("transparent flag without hit");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (ray_valid && !ray_stall) |=> a_vld)
    else $error("accepted ray word lost at pipe entry");

endmodule
